// ===== sv/fbmcu_pkg.sv =====
// Package: shared types, codes and constants of the 4-bit MCU execute unit
package fbmcu_pkg;

  localparam int unsigned StackDepthDefault = 2;
  localparam int unsigned RamWordsDefault   = 64;
  localparam int unsigned QueueDepth        = 2;

  localparam logic [12:0] PcMask       = 13'h1fff;
  localparam logic [12:0] CallPage     = 13'h03c0;
  localparam logic [7:0]  PrefixNibble = 8'h60;
  localparam logic [7:0]  HighNibble   = 8'hf0;
  localparam logic [7:0]  SegDp        = 8'h80;

  localparam logic [0:0] RegBankMask   = 1'd0;
  localparam logic [0:0] RegReturnMask = 1'd1;

  typedef enum logic [5:0] {
    ActNop  = 6'd0,  ActLai  = 6'd1,  ActLab  = 6'd2,  ActLae  = 6'd3,
    ActXab  = 6'd4,  ActXabu = 6'd5,  ActXae  = 6'd6,  ActLbe  = 6'd7,
    ActLbep = 6'd8,  ActLbz  = 6'd9,  ActLbf  = 6'd10, ActLam  = 6'd11,
    ActXc   = 6'd12, ActXci  = 6'd13, ActXcd  = 6'd14, ActStm  = 6'd15,
    ActRsm  = 6'd16, ActInp  = 6'd17, ActDisb = 6'd18, ActDisn = 6'd19,
    ActMvs  = 6'd20, ActPsh  = 6'd21, ActPsl  = 6'd22, ActEur  = 6'd23,
    ActPp   = 6'd24, ActJmp  = 6'd25, ActJms  = 6'd26, ActRt   = 6'd27,
    ActRts  = 6'd28, ActSzc  = 6'd29, ActSzm  = 6'd30, ActSzi  = 6'd31,
    ActSzk  = 6'd32, ActSbe  = 6'd33, ActSam  = 6'd34, ActTf1  = 6'd35,
    ActTf2  = 6'd36, ActAdcs = 6'd37, ActAdis = 6'd38, ActAdd  = 6'd39,
    ActAnd  = 6'd40, ActXor  = 6'd41, ActStc  = 6'd42, ActRsc  = 6'd43,
    ActCma  = 6'd44, ActSf1  = 6'd45, ActRf1  = 6'd46, ActSf2  = 6'd47,
    ActRf2  = 6'd48
  } action_t;

  typedef struct packed {
    logic [5:0]  action;
    logic [7:0]  opcode;
    logic [12:0] fetch_pc;
    logic [7:0]  d_pins_in;
    logic [3:0]  i_pins;
    logic [3:0]  k_pins;
  } item_t;

  typedef struct packed {
    logic [12:0] pc_out;
    logic        skip_next;
    logic [7:0]  d_pins_out;
    logic        d_pins_write;
    logic [12:0] a_pins_out;
    logic        a_pins_write;
  } result_t;

  typedef struct packed {
    logic [1:0]  bank_upper_mask;
    logic [12:0] return_address_mask;
  } cfg_t;

  // front classification carried with the item
  typedef struct packed {
    action_t act;
    logic    fresh;
    logic    prefixed;
  } class_t;

  typedef struct packed {
    item_t  item;
    class_t cls;
  } queued_t;

  function automatic logic [7:0] seg_lookup(input logic [3:0] v);
    logic [7:0] s;
    unique case (v)
      4'd0: s = 8'h7e;  4'd1: s = 8'h30;  4'd2: s = 8'h6d;  4'd3: s = 8'h79;
      4'd4: s = 8'h33;  4'd5: s = 8'h5b;  4'd6: s = 8'h5f;  4'd7: s = 8'h70;
      4'd8: s = 8'h7f;  4'd9: s = 8'h7b;  4'd10: s = 8'h77; 4'd11: s = 8'h1f;
      4'd12: s = 8'h4e; 4'd13: s = 8'h3d; 4'd14: s = 8'h4f; default: s = 8'h47;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/fbmcu_if.sv =====
// Interfaces: valid/ready item channel and configuration write channel
interface fbmcu_item_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbmcu_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [12:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/fbmcu_front.sv =====
// Front end: accepts items, classifies them and queues them for execution
module fbmcu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbmcu_pkg::item_t    in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output fbmcu_pkg::queued_t  q_data
);
  localparam int unsigned Depth = fbmcu_pkg::QueueDepth;

  fbmcu_pkg::queued_t       slots [Depth];
  logic                     rd_ptr, wr_ptr;
  logic [1:0]               count;
  logic [7:0]               prev_op;
  fbmcu_pkg::queued_t       entry;
  logic                     push, pop;

  assign in_ready = (count != 2'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = slots[rd_ptr];

  // prefix state follows opcode order, which the queue keeps
  always_comb begin
    entry.item         = in_data;
    entry.cls.act      = (in_data.action > 6'(fbmcu_pkg::ActRf2)) ? fbmcu_pkg::ActNop
                         : fbmcu_pkg::action_t'(in_data.action);
    entry.cls.fresh    = (prev_op & fbmcu_pkg::HighNibble)
                         != (in_data.opcode & fbmcu_pkg::HighNibble);
    entry.cls.prefixed = (prev_op & fbmcu_pkg::HighNibble) == fbmcu_pkg::PrefixNibble;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
    if (rst) begin
      rd_ptr  <= 1'b0;
      wr_ptr  <= 1'b0;
      count   <= 2'd0;
      prev_op <= 8'd0;
    end else begin
      if (push) begin
        wr_ptr  <= ~wr_ptr;
        prev_op <= in_data.opcode;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'(Depth))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'(Depth) |-> !push) else $error("push into full queue");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1) else $error("pop lost");
endmodule

// ===== sv/fbmcu_back.sv =====
// Back end: executes one queued instruction per cycle into an output register while the output is not stalled
module fbmcu_back #(
  parameter int unsigned STACK_DEPTH = fbmcu_pkg::StackDepthDefault,
  parameter int unsigned RAM_WORDS   = fbmcu_pkg::RamWordsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  fbmcu_pkg::cfg_t     cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  fbmcu_pkg::queued_t  q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fbmcu_pkg::result_t  out_data
);
  localparam int unsigned AW = $clog2(RAM_WORDS);

  logic [3:0]  acc, e_reg, bl, ism, pg_prep;
  logic        carry, d_inv, d_act;
  logic [1:0]  bu, flags;
  logic [2:0]  bk_prep;
  logic [7:0]  d_latch;
  logic [12:0] strobe;
  logic [12:0] stack [STACK_DEPTH];
  logic [3:0]  ram [RAM_WORDS];
  logic [RAM_WORDS-1:0] ram_ok;
  logic [3:0]  ram_q, byp_data;
  logic        ok_q, byp_valid;

  logic [3:0]  acc_next, e_next, bl_next, ism_next, pg_next;
  logic        carry_next, d_inv_next, d_act_next;
  logic [1:0]  bu_next, flags_next;
  logic [2:0]  bk_next;
  logic [7:0]  d_latch_next;
  logic [12:0] strobe_next;
  logic        push_stack, pop_stack, ram_we;
  logic [3:0]  ram_wdata, ram_rd;
  logic [AW-1:0] addr, rd_addr;
  fbmcu_pkg::result_t res;
  logic        fire;

  fbmcu_pkg::item_t  it;
  fbmcu_pkg::class_t cl;
  logic [1:0]  bum;
  logic [12:0] ram_mask;
  logic [3:0]  bitm, dmask;
  logic [4:0]  sum;
  logic [7:0]  tval;
  logic [12:0] jt, jm;

  assign it       = q_data.item;
  assign cl       = q_data.cls;
  assign bum      = cfg.bank_upper_mask;
  assign ram_mask = cfg.return_address_mask;
  assign q_ready  = !out_valid || out_ready;
  assign fire     = q_valid && q_ready;
  assign addr     = AW'({bu, bl});
  // read ahead at the pointer the next item will see; forward a write to that entry
  assign rd_addr  = fire ? AW'({bu_next, bl_next}) : addr;
  // entries not written since reset read as zero (valid bit per entry)
  assign ram_rd   = byp_valid ? byp_data : (ok_q ? ram_q : 4'd0);
  assign bitm     = 4'd1 << it.opcode[1:0];

  always_comb begin
    acc_next = acc; e_next = e_reg; bl_next = bl; ism_next = ism; pg_next = pg_prep;
    carry_next = carry; d_inv_next = d_inv; d_act_next = d_act; bu_next = bu;
    flags_next = flags; bk_next = bk_prep; d_latch_next = d_latch;
    strobe_next = strobe; push_stack = 1'b0; pop_stack = 1'b0;
    ram_we = 1'b0; ram_wdata = acc; sum = 5'd0; tval = 8'd0; dmask = 4'd0;
    jt = 13'd0; jm = 13'd0;
    res = '0;
    res.pc_out = it.fetch_pc;
    // jump target, page prefix widens it to the full range
    if (cl.prefixed) begin
      jt = {bk_prep, pg_prep, it.opcode[5:0]};
      jm = fbmcu_pkg::PcMask;
    end else begin
      jt = {7'd0, it.opcode[5:0]};
      jm = 13'h003f;
    end
    dmask = {2'b00, ~it.opcode[1:0] & bum};
    unique case (cl.act)
      fbmcu_pkg::ActLai: if (cl.fresh) begin
        acc_next = it.opcode[3:0]; ism_next = it.opcode[3:0];
      end
      fbmcu_pkg::ActLab: acc_next = bl;
      fbmcu_pkg::ActLae: acc_next = e_reg;
      fbmcu_pkg::ActXab: begin acc_next = bl; bl_next = acc; end
      fbmcu_pkg::ActXabu: begin
        acc_next = (acc & ~{2'b00, bum}) | {2'b00, bu & bum};
        bu_next  = acc[1:0] & bum;
      end
      fbmcu_pkg::ActXae: begin acc_next = e_reg; e_next = acc; end
      fbmcu_pkg::ActLbe, fbmcu_pkg::ActLbep, fbmcu_pkg::ActLbz,
      fbmcu_pkg::ActLbf: if (cl.fresh) begin
        bu_next = it.opcode[1:0] & bum;
        priority case (cl.act)
          fbmcu_pkg::ActLbe:  bl_next = e_reg;
          fbmcu_pkg::ActLbep: bl_next = e_reg + 4'd1;
          fbmcu_pkg::ActLbz:  bl_next = 4'd0;
          default:            bl_next = 4'hf;
        endcase
      end
      fbmcu_pkg::ActLam: begin acc_next = ram_rd; bu_next = bu ^ dmask[1:0]; end
      fbmcu_pkg::ActXc, fbmcu_pkg::ActXci, fbmcu_pkg::ActXcd: begin
        acc_next = ram_rd; ram_we = 1'b1; ram_wdata = acc; bu_next = bu ^ dmask[1:0];
        if (cl.act == fbmcu_pkg::ActXci) begin
          bl_next = bl + 4'd1; res.skip_next = (bl_next == 4'd0);
        end else if (cl.act == fbmcu_pkg::ActXcd) begin
          bl_next = bl - 4'd1; res.skip_next = (bl_next == 4'hf);
        end
      end
      fbmcu_pkg::ActStm: begin ram_we = 1'b1; ram_wdata = ram_rd | bitm; end
      fbmcu_pkg::ActRsm: begin ram_we = 1'b1; ram_wdata = ram_rd & ~bitm; end
      fbmcu_pkg::ActInp: begin
        tval = d_act ? d_latch : it.d_pins_in;
        acc_next = tval[3:0]; ram_we = 1'b1; ram_wdata = tval[7:4];
      end
      fbmcu_pkg::ActDisb, fbmcu_pkg::ActDisn: begin
        d_latch_next = (cl.act == fbmcu_pkg::ActDisb) ? {ram_rd, acc}
                       : (fbmcu_pkg::seg_lookup(acc) | (carry ? fbmcu_pkg::SegDp : 8'd0));
        d_act_next = 1'b1; res.d_pins_write = 1'b1;
        res.d_pins_out = d_latch_next ^ {8{d_inv}};
      end
      fbmcu_pkg::ActMvs: begin
        d_act_next = 1'b0; res.d_pins_write = 1'b1;
        res.a_pins_out = strobe; res.a_pins_write = 1'b1;
      end
      fbmcu_pkg::ActPsh, fbmcu_pkg::ActPsl: begin
        if (bl == 4'he) begin
          d_act_next = (cl.act == fbmcu_pkg::ActPsh); res.d_pins_write = 1'b1;
          res.d_pins_out = d_act_next ? (d_latch ^ {8{d_inv}}) : 8'd0;
        end else if (bl == 4'hf) begin
          strobe_next = (cl.act == fbmcu_pkg::ActPsh) ? fbmcu_pkg::PcMask : 13'd0;
        end else if (bl < 4'hd) begin
          if (cl.act == fbmcu_pkg::ActPsh) strobe_next = strobe | (13'd1 << bl);
          else strobe_next = strobe & ~(13'd1 << bl);
        end
      end
      fbmcu_pkg::ActEur: begin
        d_inv_next = ~acc[0]; res.d_pins_write = 1'b1;
        res.d_pins_out = d_act ? (d_latch ^ {8{d_inv_next}}) : 8'd0;
      end
      fbmcu_pkg::ActPp: if (cl.fresh) pg_next = ~it.opcode[3:0];
                        else bk_next = ~it.opcode[2:0];
      fbmcu_pkg::ActJmp: res.pc_out = (it.fetch_pc & ~jm) | jt;
      fbmcu_pkg::ActJms: begin
        push_stack = 1'b1;
        res.pc_out = (it.fetch_pc & ~jm) | jt;
        if (!cl.prefixed) res.pc_out = res.pc_out | fbmcu_pkg::CallPage;
      end
      fbmcu_pkg::ActRt, fbmcu_pkg::ActRts: begin
        pop_stack = 1'b1;
        res.pc_out = (it.fetch_pc & ~ram_mask) | (stack[0] & ram_mask);
        res.skip_next = (cl.act == fbmcu_pkg::ActRts);
      end
      fbmcu_pkg::ActSzc: res.skip_next = ~carry;
      fbmcu_pkg::ActSzm: res.skip_next = ((ram_rd & bitm) == 4'd0);
      fbmcu_pkg::ActSzi: res.skip_next = ((~it.i_pins & ism) != 4'd0);
      fbmcu_pkg::ActSzk: res.skip_next = ((~it.k_pins & ism) != 4'd0);
      fbmcu_pkg::ActSbe: res.skip_next = (bl == e_reg);
      fbmcu_pkg::ActSam: res.skip_next = (acc == ram_rd);
      fbmcu_pkg::ActTf1: res.skip_next = flags[0];
      fbmcu_pkg::ActTf2: res.skip_next = flags[1];
      fbmcu_pkg::ActAdcs: begin
        sum = 5'(acc) + 5'(ram_rd) + 5'(carry);
        carry_next = sum[4]; res.skip_next = ~sum[4]; acc_next = sum[3:0];
      end
      fbmcu_pkg::ActAdis: begin
        sum = 5'(acc) + 5'(it.opcode[3:0]);
        res.skip_next = ~sum[4]; acc_next = sum[3:0];
      end
      fbmcu_pkg::ActAdd: acc_next = acc + ram_rd;
      fbmcu_pkg::ActAnd: acc_next = acc & ram_rd;
      fbmcu_pkg::ActXor: acc_next = acc ^ ram_rd;
      fbmcu_pkg::ActStc: carry_next = 1'b1;
      fbmcu_pkg::ActRsc: carry_next = 1'b0;
      fbmcu_pkg::ActCma: acc_next = ~acc;
      fbmcu_pkg::ActSf1: flags_next = flags | 2'b01;
      fbmcu_pkg::ActRf1: flags_next = flags & 2'b10;
      fbmcu_pkg::ActSf2: flags_next = flags | 2'b10;
      fbmcu_pkg::ActRf2: flags_next = flags & 2'b01;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && ram_we) begin
      ram[addr] <= ram_wdata;
    end
    ram_q    <= ram[rd_addr];
    byp_data <= ram_wdata;
    if (fire) begin
      out_data <= res;
    end
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= 13'd0;
      out_valid <= 1'b0; ram_ok <= '0; ok_q <= 1'b0; byp_valid <= 1'b0;
      acc <= '0; e_reg <= '0; bl <= '0; ism <= '0; pg_prep <= '0;
      carry <= 1'b0; d_inv <= 1'b0; d_act <= 1'b0; bu <= '0; flags <= '0;
      bk_prep <= '0; d_latch <= '0; strobe <= '0;
    end else begin
      ok_q      <= ram_ok[rd_addr];
      byp_valid <= fire && ram_we && (rd_addr == addr);
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) begin
        if (push_stack) begin
          for (int i = STACK_DEPTH - 1; i >= 1; i--) stack[i] <= stack[i-1];
          stack[0] <= it.fetch_pc & ram_mask;
        end else if (pop_stack) begin
          for (int i = 0; i < STACK_DEPTH - 1; i++) stack[i] <= stack[i+1];
        end
        if (ram_we) ram_ok[addr] <= 1'b1;
        acc <= acc_next; e_reg <= e_next; bl <= bl_next; ism <= ism_next;
        pg_prep <= pg_next; carry <= carry_next; d_inv <= d_inv_next;
        d_act <= d_act_next; bu <= bu_next; flags <= flags_next; bk_prep <= bk_next;
        d_latch <= d_latch_next; strobe <= strobe_next;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_ptr_bank: assert property (@(posedge clk) disable iff (rst)
    fire && (cl.act == fbmcu_pkg::ActLbz) && cl.fresh |=> bl == 4'd0)
    else $error("pointer load failed");
  a_pins_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.a_pins_write |-> out_data.a_pins_out == 13'd0)
    else $error("A pins driven without write");
endmodule

// ===== sv/four_bit_mcu_execute_unit.sv =====
// Top level: 4-bit MCU execute unit, front queue plus execution back end
//  channel   dir   handshake      payload
//  in        sink  valid/ready    fbmcu_pkg::item_t
//  out       src   valid/ready    fbmcu_pkg::result_t
//  cfg       sink  valid/ready    index, wdata
// One instruction per cycle if not stalled; result appears the cycle after dequeue.
// A two-entry queue decouples input from the execute stage and its output register.
// Sync reset (rst) resets control state; RAM entries read zero until written.
// Output stalls hold the result register and back up into the queue.
module four_bit_mcu_execute_unit #(
  parameter int unsigned STACK_DEPTH = fbmcu_pkg::StackDepthDefault,
  parameter int unsigned RAM_WORDS   = fbmcu_pkg::RamWordsDefault
) (
  input logic clk,
  input logic rst,
  fbmcu_item_if.sink   in,
  fbmcu_item_if.source out,
  fbmcu_cfg_if.sink    cfg
);
  fbmcu_pkg::cfg_t     cfg_regs;
  logic                q_valid, q_ready;
  fbmcu_pkg::queued_t  q_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.bank_upper_mask     <= 2'd3;
      cfg_regs.return_address_mask <= 13'd63;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fbmcu_pkg::RegBankMask:   cfg_regs.bank_upper_mask <= cfg.wdata[1:0];
        fbmcu_pkg::RegReturnMask: cfg_regs.return_address_mask <= cfg.wdata;
        default: ;
      endcase
    end
  end

  fbmcu_front u_front (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready), .in_data(in.data),
    .q_valid, .q_ready, .q_data
  );

  fbmcu_back #(.STACK_DEPTH(STACK_DEPTH), .RAM_WORDS(RAM_WORDS)) u_back (
    .clk, .rst, .cfg(cfg_regs),
    .q_valid, .q_ready, .q_data,
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
  );
endmodule

// ===== tb/tb_top.sv =====
// Testbench: directed and random instruction streams checked against a local predictor
`timescale 1ns / 100ps

module tb;
  localparam logic [5:0] UnusedAction = 6'd63;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fbmcu_item_if #(.payload_t(fbmcu_pkg::item_t))   in_if ();
  fbmcu_item_if #(.payload_t(fbmcu_pkg::result_t)) out_if ();
  fbmcu_cfg_if                                     cfg_if ();

  four_bit_mcu_execute_unit u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_if.sink),
    .out (out_if.source),
    .cfg (cfg_if.sink)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [1:0]  p_bmask;
  logic [12:0] p_rmask;
  logic [3:0]  p_acc, p_e, p_bl, p_ism, p_page;
  logic        p_cy, p_dinv, p_dact;
  logic [1:0]  p_bu, p_flags;
  logic [2:0]  p_bank;
  logic [3:0]  p_ram [64];
  logic [12:0] p_stk [2];
  logic [7:0]  p_prev, p_dlat;
  logic [12:0] p_strobe;

  fbmcu_pkg::result_t pending_results[$];
  int      errors = 0;
  logic    hold_off = 1'b0;
  logic    no_idle = 1'b0;

  function automatic logic [7:0] seg_of(input logic [3:0] v);
    logic [7:0] s;
    case (v)
      4'd0: s = 8'h7e;  4'd1: s = 8'h30;  4'd2: s = 8'h6d;  4'd3: s = 8'h79;
      4'd4: s = 8'h33;  4'd5: s = 8'h5b;  4'd6: s = 8'h5f;  4'd7: s = 8'h70;
      4'd8: s = 8'h7f;  4'd9: s = 8'h7b;  4'd10: s = 8'h77; 4'd11: s = 8'h1f;
      4'd12: s = 8'h4e; 4'd13: s = 8'h3d; 4'd14: s = 8'h4f; default: s = 8'h47;
    endcase
    return s;
  endfunction

  task automatic reset_model();
    p_bmask = 2'd3; p_rmask = 13'd63;
    p_acc = '0; p_e = '0; p_bl = '0; p_ism = '0; p_page = '0; p_cy = 1'b0;
    p_dinv = 1'b0; p_dact = 1'b0; p_bu = '0; p_flags = '0; p_bank = '0;
    p_prev = '0; p_dlat = '0; p_strobe = '0;
    for (int i = 0; i < 64; i++) p_ram[i] = 4'd0;
    p_stk[0] = 13'd0; p_stk[1] = 13'd0;
  endtask

  task automatic drive_d(input logic on, inout fbmcu_pkg::result_t r);
    r.d_pins_out = on ? (p_dlat ^ {8{p_dinv}}) : 8'h00;
    r.d_pins_write = 1'b1;
    p_dact = on;
  endtask

  task automatic do_jump(input logic [7:0] op, inout logic [12:0] pc);
    logic [12:0] m, tg;
    m = 13'h3f; tg = {7'd0, op[5:0]};
    if ((p_prev & fbmcu_pkg::HighNibble) == fbmcu_pkg::PrefixNibble) begin
      tg = tg | {p_bank, p_page, 6'd0};
      m = fbmcu_pkg::PcMask;
    end
    pc = (pc & ~m) | tg;
  endtask

  task automatic pop_stack(inout logic [12:0] pc);
    pc = (pc & ~p_rmask) | (p_stk[0] & p_rmask);
    p_stk[0] = p_stk[1];
  endtask

  task automatic xchg_ram(input logic [7:0] op, input logic [5:0] a);
    logic [3:0] t;
    t = p_acc; p_acc = p_ram[a]; p_ram[a] = t;
    p_bu = p_bu ^ (~op[1:0] & p_bmask);
  endtask

  task automatic predict_instruction(input fbmcu_pkg::item_t it);
    fbmcu_pkg::result_t r;
    logic [12:0] pc;
    logic [7:0] op, t8;
    logic [5:0] a;
    logic [3:0] bitm, m;
    logic [4:0] s5;
    logic       fresh, sk;
    op = it.opcode; pc = it.fetch_pc; sk = 1'b0;
    r = '0;
    fresh = p_prev[7:4] != op[7:4];
    bitm = 4'd1 << op[1:0];
    a = {p_bu, p_bl};
    m = p_ram[a];
    case (it.action)
      fbmcu_pkg::ActLai: if (fresh) begin p_acc = op[3:0]; p_ism = op[3:0]; end
      fbmcu_pkg::ActLab: p_acc = p_bl;
      fbmcu_pkg::ActLae: p_acc = p_e;
      fbmcu_pkg::ActXab: begin t8 = {4'd0, p_acc}; p_acc = p_bl; p_bl = t8[3:0]; end
      fbmcu_pkg::ActXabu: begin
        t8 = {4'd0, p_acc};
        p_acc = (p_acc & ~{2'b00, p_bmask}) | {2'b00, p_bu & p_bmask};
        p_bu = t8[1:0] & p_bmask;
      end
      fbmcu_pkg::ActXae: begin t8 = {4'd0, p_acc}; p_acc = p_e; p_e = t8[3:0]; end
      fbmcu_pkg::ActLbe, fbmcu_pkg::ActLbep, fbmcu_pkg::ActLbz,
      fbmcu_pkg::ActLbf: if (fresh) begin
        p_bu = op[1:0] & p_bmask;
        case (it.action)
          fbmcu_pkg::ActLbe: p_bl = p_e;
          fbmcu_pkg::ActLbep: p_bl = p_e + 4'd1;
          fbmcu_pkg::ActLbz: p_bl = 4'd0;
          default: p_bl = 4'hf;
        endcase
      end
      fbmcu_pkg::ActLam: begin p_acc = m; p_bu = p_bu ^ (~op[1:0] & p_bmask); end
      fbmcu_pkg::ActXc: xchg_ram(op, a);
      fbmcu_pkg::ActXci: begin
        xchg_ram(op, a); p_bl = p_bl + 4'd1; sk = p_bl == 4'd0;
      end
      fbmcu_pkg::ActXcd: begin
        xchg_ram(op, a); p_bl = p_bl - 4'd1; sk = p_bl == 4'hf;
      end
      fbmcu_pkg::ActStm: p_ram[a] = m | bitm;
      fbmcu_pkg::ActRsm: p_ram[a] = m & ~bitm;
      fbmcu_pkg::ActInp: begin
        t8 = p_dact ? p_dlat : it.d_pins_in;
        p_acc = t8[3:0]; p_ram[a] = t8[7:4];
      end
      fbmcu_pkg::ActDisb: begin p_dlat = {m, p_acc}; drive_d(1'b1, r); end
      fbmcu_pkg::ActDisn: begin
        p_dlat = seg_of(p_acc) | (p_cy ? fbmcu_pkg::SegDp : 8'h00);
        drive_d(1'b1, r);
      end
      fbmcu_pkg::ActMvs: begin
        drive_d(1'b0, r); r.a_pins_out = p_strobe; r.a_pins_write = 1'b1;
      end
      fbmcu_pkg::ActPsh: begin
        if (p_bl == 4'he) drive_d(1'b1, r);
        else if (p_bl == 4'hf) p_strobe = fbmcu_pkg::PcMask;
        else if (p_bl < 4'hd) p_strobe = p_strobe | (13'd1 << p_bl);
      end
      fbmcu_pkg::ActPsl: begin
        if (p_bl == 4'he) drive_d(1'b0, r);
        else if (p_bl == 4'hf) p_strobe = 13'd0;
        else if (p_bl < 4'hd) p_strobe = p_strobe & ~(13'd1 << p_bl);
      end
      fbmcu_pkg::ActEur: begin p_dinv = ~p_acc[0]; drive_d(p_dact, r); end
      fbmcu_pkg::ActPp: if (fresh) p_page = ~op[3:0]; else p_bank = ~op[2:0];
      fbmcu_pkg::ActJmp: do_jump(op, pc);
      fbmcu_pkg::ActJms: begin
        p_stk[1] = p_stk[0];
        p_stk[0] = pc & p_rmask;
        do_jump(op, pc);
        if ((p_prev & fbmcu_pkg::HighNibble) != fbmcu_pkg::PrefixNibble)
          pc = pc | fbmcu_pkg::CallPage;
      end
      fbmcu_pkg::ActRt: pop_stack(pc);
      fbmcu_pkg::ActRts: begin pop_stack(pc); sk = 1'b1; end
      fbmcu_pkg::ActSzc: sk = !p_cy;
      fbmcu_pkg::ActSzm: sk = (m & bitm) == 4'd0;
      fbmcu_pkg::ActSzi: sk = (~it.i_pins & p_ism) != 4'd0;
      fbmcu_pkg::ActSzk: sk = (~it.k_pins & p_ism) != 4'd0;
      fbmcu_pkg::ActSbe: sk = p_bl == p_e;
      fbmcu_pkg::ActSam: sk = p_acc == m;
      fbmcu_pkg::ActTf1: sk = p_flags[0];
      fbmcu_pkg::ActTf2: sk = p_flags[1];
      fbmcu_pkg::ActAdcs: begin
        s5 = 5'(p_acc) + 5'(m) + 5'(p_cy);
        p_cy = s5[4]; sk = !s5[4]; p_acc = s5[3:0];
      end
      fbmcu_pkg::ActAdis: begin
        s5 = 5'(p_acc) + 5'(op[3:0]); sk = !s5[4]; p_acc = s5[3:0];
      end
      fbmcu_pkg::ActAdd: p_acc = p_acc + m;
      fbmcu_pkg::ActAnd: p_acc = p_acc & m;
      fbmcu_pkg::ActXor: p_acc = p_acc ^ m;
      fbmcu_pkg::ActStc: p_cy = 1'b1;
      fbmcu_pkg::ActRsc: p_cy = 1'b0;
      fbmcu_pkg::ActCma: p_acc = ~p_acc;
      fbmcu_pkg::ActSf1: p_flags[0] = 1'b1;
      fbmcu_pkg::ActRf1: p_flags[0] = 1'b0;
      fbmcu_pkg::ActSf2: p_flags[1] = 1'b1;
      fbmcu_pkg::ActRf2: p_flags[1] = 1'b0;
      default: ;
    endcase
    p_prev = op;
    r.pc_out = pc;
    r.skip_next = sk;
    pending_results.push_back(r);
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 14);
  endfunction

  // valid stays high between back-to-back items; drop it only while idling
  task automatic send_instruction(input fbmcu_pkg::item_t it);
    while (idle_now()) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_instruction(it);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [12:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == fbmcu_pkg::RegBankMask) p_bmask = v[1:0];
    else p_rmask = v;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic fbmcu_pkg::item_t rand_instruction(input logic [5:0] act);
    fbmcu_pkg::item_t it;
    it.action = act;
    it.opcode = 8'($urandom);
    it.fetch_pc = 13'($urandom);
    it.d_pins_in = 8'($urandom);
    it.i_pins = 4'($urandom);
    it.k_pins = 4'($urandom);
    return it;
  endfunction

  task automatic send_op(input logic [5:0] act, input logic [7:0] op);
    fbmcu_pkg::item_t it;
    it = rand_instruction(act);
    it.opcode = op;
    send_instruction(it);
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    fbmcu_pkg::result_t e;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_if.data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_if.data !== e) begin
          $display("%0t: mismatch expected pc %h skip %b d %h/%b a %h/%b", $time,
                   e.pc_out, e.skip_next, e.d_pins_out, e.d_pins_write,
                   e.a_pins_out, e.a_pins_write);
          $display("%0t:          actual   pc %h skip %b d %h/%b a %h/%b", $time,
                   out_if.data.pc_out, out_if.data.skip_next, out_if.data.d_pins_out,
                   out_if.data.d_pins_write, out_if.data.a_pins_out,
                   out_if.data.a_pins_write);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= !hold_off && !idle_now();
  end

  task automatic test_directed();
    // prefix handling, strobe presets, pins, stack, add-and-skip ops and an unused action code
    send_op(fbmcu_pkg::ActLai, 8'h15);
    send_op(fbmcu_pkg::ActLai, 8'h1a);
    send_op(fbmcu_pkg::ActLbf, 8'h23);
    send_op(fbmcu_pkg::ActPsh, 8'h00);
    send_op(fbmcu_pkg::ActMvs, 8'h00);
    send_op(fbmcu_pkg::ActLbz, 8'h33);
    send_op(fbmcu_pkg::ActXcd, 8'h40);
    send_op(fbmcu_pkg::ActPsh, 8'h00);
    send_op(fbmcu_pkg::ActLae, 8'h00);
    send_op(fbmcu_pkg::ActXcd, 8'h43);
    send_op(fbmcu_pkg::ActPsh, 8'h00);
    send_op(fbmcu_pkg::ActDisn, 8'h00);
    send_op(fbmcu_pkg::ActEur, 8'h00);
    send_op(fbmcu_pkg::ActInp, 8'h00);
    send_op(fbmcu_pkg::ActPsl, 8'h00);
    send_op(fbmcu_pkg::ActPp, 8'h65);
    send_op(fbmcu_pkg::ActPp, 8'h62);
    send_op(fbmcu_pkg::ActJms, 8'h7f);
    send_op(fbmcu_pkg::ActJms, 8'h81);
    send_op(fbmcu_pkg::ActRts, 8'h00);
    send_op(fbmcu_pkg::ActRt, 8'h00);
    send_op(fbmcu_pkg::ActAdis, 8'hff);
    send_op(fbmcu_pkg::ActAdcs, 8'h00);
    send_op(UnusedAction, 8'hff);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    fbmcu_pkg::item_t it;
    for (int i = 0; i < n; i++) begin
      it = rand_instruction($urandom_range(99) < 90 ? 6'($urandom_range(48)) : 6'($urandom));
      // bias the high nibble to repeat or be the prefix so both paths are taken
      case ($urandom_range(3))
        0: it.opcode[7:4] = p_prev[7:4];
        1: it.opcode[7:4] = fbmcu_pkg::PrefixNibble[7:4];
        default: ;
      endcase
      send_instruction(it);
    end
  endtask

  task automatic test_config_sweep();
    logic [12:0] rm [4] = '{13'd0, 13'h1fff, 13'd63, 13'h0f0f};
    for (int k = 0; k < 4; k++) begin
      write_register(fbmcu_pkg::RegBankMask, 13'(k));
      write_register(fbmcu_pkg::RegReturnMask, rm[k]);
      no_idle = (k == 1);
      test_random(300);
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
    wait_drained();
    // sender pause with everything drained, then continue
    test_random(440);
    wait_drained();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    write_register(fbmcu_pkg::RegBankMask, 13'd3);
    write_register(fbmcu_pkg::RegReturnMask, 13'd63);
    test_backpressure();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
